// ===== rtl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants of the Catmull-Rom stroke subdivider.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned DIN_W      = 50;
  localparam int unsigned DIV_W      = 52;
  localparam int unsigned Q_W        = DIV_W + 1;
  localparam int unsigned M_W        = 15;

  localparam logic [7:0]         REG_TENSION = 8'd0;
  localparam logic [7:0]         REG_SUBDIV  = 8'd1;
  localparam logic signed [15:0] TENSION_RST = 16'sd8192;
  localparam logic [4:0]         SUBDIV_RST  = 5'd4;
  localparam logic [4:0]         SUBDIV_DFLT = 5'd4;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_SEG0  = 3'd1;
  localparam logic [2:0] STEP_MID   = 3'd2;
  localparam logic [2:0] STEP_LAST  = 3'd3;
  localparam logic [2:0] STEP_ERR   = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        pr;
    logic [31:0]        st;
  } pt_t;

  typedef enum logic [1:0] {
    JOB_FIRST,
    JOB_SEG,
    JOB_ERR
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    pt_t                a;
    pt_t                b;
    pt_t                c;
    pt_t                d;
    logic [4:0]         n;
    logic signed [16:0] k;
    logic               last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [0:0] {
    F_IDLE,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_CUBE,
    B_MUL,
    B_SUM,
    B_KMUL,
    B_PRE,
    B_DIV,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/crs_fifo.sv =====
// ----------------------------------------------------------------------------
// crs_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire crs_pkg::job_t   din,
  input  wire logic            pop,
  output crs_pkg::job_t        dout,
  output crs_pkg::q_stat_t     stat
);

  localparam int unsigned DEPTH = crs_pkg::FIFO_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  crs_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
    else $error("job popped from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/crs_front.sv =====
// ----------------------------------------------------------------------------
// crs_front
// Accepts stroke points, keeps the three-point window and the configuration,
// and turns later points into curve jobs (or an error job) for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_front #(
  parameter int MAX_SUBDIV = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic [15:0]        in_pen_pressure,
  input  wire logic [31:0]        in_stamp,
  input  wire logic               in_final_point,
  input  wire logic               cfg_valid,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    push,
  output crs_pkg::job_t           job,
  input  wire crs_pkg::q_stat_t   qstat
);

  localparam logic [4:0] NMAX = 5'(MAX_SUBDIV);

  crs_pkg::front_state_t state_r, state_nxt;
  crs_pkg::pt_t          win_r [3];
  crs_pkg::pt_t          win_nxt [3];
  crs_pkg::pt_t          q_r, q_nxt, q_in;
  logic                  fin_r, fin_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [2:0]            end_r, end_nxt;
  logic [2:0]            seen_r, seen_nxt;
  logic signed [15:0]    tension_r, tension_nxt;
  logic [4:0]            subdiv_r, subdiv_nxt;
  logic [4:0]            n0, n_eff;
  logic                  accept, go;

  assign q_in.x  = in_pos_x;
  assign q_in.y  = in_pos_y;
  assign q_in.pr = in_pen_pressure;
  assign q_in.st = in_stamp;
  assign accept  = in_valid && in_ready;
  assign go      = (seen_r >= 3'd3) || in_final_point;
  assign n0      = (subdiv_r == 5'd0) ? crs_pkg::SUBDIV_DFLT : subdiv_r;
  assign n_eff   = (n0 > NMAX) ? NMAX : n0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crs_pkg::F_IDLE: begin
        if (accept && go) begin
          state_nxt = crs_pkg::F_PUSH;
        end
      end
      crs_pkg::F_PUSH: begin
        if (push && step_r == end_r) begin
          state_nxt = crs_pkg::F_IDLE;
        end
      end
      default: state_nxt = crs_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state_r)
      crs_pkg::F_IDLE: in_ready = 1'b1;
      crs_pkg::F_PUSH: push = !qstat.full;
      default: begin
      end
    endcase
  end

  always_comb begin
    job      = '0;
    job.n    = n_eff;
    job.k    = 17'sd16384 - 17'(tension_r);
    job.last = (step_r == end_r);
    job.kind = crs_pkg::JOB_SEG;
    case (step_r)
      crs_pkg::STEP_FIRST: begin
        job.kind = crs_pkg::JOB_FIRST;
        job.a    = win_r[0];
      end
      crs_pkg::STEP_SEG0: begin
        job.a = win_r[0];
        job.b = win_r[0];
        job.c = win_r[1];
        job.d = win_r[2];
      end
      crs_pkg::STEP_MID: begin
        job.a = win_r[0];
        job.b = win_r[1];
        job.c = win_r[2];
        job.d = q_r;
      end
      crs_pkg::STEP_LAST: begin
        job.a = win_r[1];
        job.b = win_r[2];
        job.c = q_r;
        job.d = q_r;
      end
      default: job.kind = crs_pkg::JOB_ERR;
    endcase
  end

  always_comb begin
    win_nxt     = win_r;
    q_nxt       = q_r;
    fin_nxt     = fin_r;
    step_nxt    = step_r;
    end_nxt     = end_r;
    seen_nxt    = seen_r;
    tension_nxt = tension_r;
    subdiv_nxt  = subdiv_r;
    if (cfg_valid) begin
      case (cfg_index)
        crs_pkg::REG_TENSION: tension_nxt = cfg_data;
        crs_pkg::REG_SUBDIV:  subdiv_nxt  = cfg_data[4:0];
        default: begin
        end
      endcase
    end
    if (accept) begin
      q_nxt   = q_in;
      fin_nxt = in_final_point;
      if (!go) begin
        win_nxt[seen_r[1:0]] = q_in;
        seen_nxt             = seen_r + 3'd1;
      end else if (seen_r < 3'd3) begin
        step_nxt = crs_pkg::STEP_ERR;
        end_nxt  = crs_pkg::STEP_ERR;
      end else begin
        step_nxt = (seen_r == 3'd3) ? crs_pkg::STEP_FIRST : crs_pkg::STEP_MID;
        end_nxt  = in_final_point ? crs_pkg::STEP_LAST : crs_pkg::STEP_MID;
      end
    end
    if (push) begin
      if (step_r == end_r) begin
        if (fin_r) begin
          seen_nxt = 3'd0;
        end else begin
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = q_r;
          seen_nxt   = 3'd4;
        end
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= crs_pkg::F_IDLE;
      seen_r    <= 3'd0;
      tension_r <= crs_pkg::TENSION_RST;
      subdiv_r  <= crs_pkg::SUBDIV_RST;
      step_r    <= crs_pkg::STEP_FIRST;
      end_r     <= crs_pkg::STEP_FIRST;
      fin_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      tension_r <= tension_nxt;
      subdiv_r  <= subdiv_nxt;
      step_r    <= step_nxt;
      end_r     <= end_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    q_r   <= q_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/crs_div.sv =====
// ----------------------------------------------------------------------------
// crs_div
// Iterative floor divider, signed dividend by unsigned divisor,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [crs_pkg::DIN_W-1:0]   num,
  input  wire logic [crs_pkg::M_W-1:0]            den,
  output logic                                    busy,
  output logic signed [crs_pkg::Q_W-1:0]          quo
);

  localparam int unsigned IW    = crs_pkg::DIN_W;
  localparam int unsigned DW    = crs_pkg::DIV_W;
  localparam int unsigned MW    = crs_pkg::M_W;
  localparam int unsigned STEPS = DW / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [DW-1:0] dq_r, dq_step, dvd;
  logic [MW-1:0] rem_r, rem_step, den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [IW-1:0] mag;

  assign mag = num[IW-1] ? IW'(-num) : IW'(num);
  assign dvd = num[IW-1] ? DW'(mag) + DW'(den) - DW'(1) : DW'(mag);

  always_comb begin
    logic [MW:0]   r2;
    logic [MW-1:0] r;
    logic [DW-1:0] d;
    r = rem_r;
    d = dq_r;
    for (int i = 0; i < 2; i++) begin
      r2 = {r, d[DW-1]};
      d  = {d[DW-2:0], 1'b0};
      if (r2 >= {1'b0, den_r}) begin
        r2   = r2 - {1'b0, den_r};
        d[0] = 1'b1;
      end
      r = r2[MW-1:0];
    end
    rem_step = r;
    dq_step  = d;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(STEPS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dvd;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[IW-1];
    end else if (busy_r) begin
      dq_r  <= dq_step;
      rem_r <= rem_step;
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

endmodule

`default_nettype wire

// ===== rtl/crs_back.sv =====
// ----------------------------------------------------------------------------
// crs_back
// Carries out queued jobs: Hermite blending of x, y and pressure, linear
// stamp interpolation, rounding division and saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire crs_pkg::job_t      head,
  input  wire crs_pkg::q_stat_t   qstat,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic [15:0]             out_pressure,
  output logic [31:0]             out_stamp,
  output logic                    out_run_end,
  output logic                    out_status
);

  localparam int unsigned QW = crs_pkg::Q_W;
  localparam int unsigned IW = crs_pkg::DIN_W;
  localparam int unsigned MW = crs_pkg::M_W;
  localparam logic signed [QW-1:0] S32_MAX = QW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [QW-1:0] S32_MIN = QW'(-64'sh0000_0000_8000_0000);
  localparam logic signed [QW-1:0] U16_MAX = QW'(64'sh0000_0000_0000_FFFF);

  crs_pkg::back_state_t state_r, state_nxt;
  crs_pkg::job_t        job_r;
  logic [4:0]           j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 free, start, last_pt;
  logic [3:0]           busy;

  logic [9:0]           j2_r, n2_r, jn_r;
  logic [MW-1:0]        j3, j2n, jn2, n3, m_r;
  logic signed [17:0]   cj3, cj2n, cjn2, cn3;
  logic signed [15:0]   h1_r, h2_r, h3_r, h4_r;
  logic signed [32:0]   v [3][4];
  logic signed [33:0]   d20_r [3];
  logic signed [33:0]   d31_r [3];
  logic signed [49:0]   p1_r [3];
  logic signed [49:0]   p2_r [3];
  logic signed [49:0]   p3_r [3];
  logic signed [49:0]   p4_r [3];
  logic signed [50:0]   s_r [3];
  logic signed [50:0]   t_r [3];
  logic signed [63:0]   kt_r [3];
  logic signed [63:0]   num [3];
  logic signed [39:0]   sb_r, sj_r, ns_r;
  logic signed [33:0]   dst;
  logic signed [IW-1:0] dnum [4];
  logic [MW-1:0]        dden [4];
  logic signed [QW-1:0] quo [4];

  logic signed [31:0]   rx, ry;
  logic [15:0]          rp;
  logic [31:0]          rs;

  assign free = !out_valid_r || out_ready;

  always_comb begin
    v[0][0] = 33'(job_r.a.x);
    v[0][1] = 33'(job_r.b.x);
    v[0][2] = 33'(job_r.c.x);
    v[0][3] = 33'(job_r.d.x);
    v[1][0] = 33'(job_r.a.y);
    v[1][1] = 33'(job_r.b.y);
    v[1][2] = 33'(job_r.c.y);
    v[1][3] = 33'(job_r.d.y);
    v[2][0] = $signed({17'd0, job_r.a.pr});
    v[2][1] = $signed({17'd0, job_r.b.pr});
    v[2][2] = $signed({17'd0, job_r.c.pr});
    v[2][3] = $signed({17'd0, job_r.d.pr});
  end

  assign j3   = MW'(j2_r) * MW'(j_r);
  assign j2n  = MW'(j2_r) * MW'(job_r.n);
  assign jn2  = MW'(jn_r) * MW'(job_r.n);
  assign n3   = MW'(n2_r) * MW'(job_r.n);
  assign cj3  = 18'(j3);
  assign cj2n = 18'(j2n);
  assign cjn2 = 18'(jn2);
  assign cn3  = 18'(n3);
  assign dst  = $signed({2'b00, job_r.c.st}) - $signed({2'b00, job_r.b.st});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = (64'(s_r[c]) <<< 15) + kt_r[c] + $signed(64'({m_r, 14'd0}));
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dnum[c] = IW'($signed(num[c][63:15]));
      dden[c] = m_r;
    end
    dnum[3] = IW'(ns_r);
    dden[3] = MW'(job_r.n);
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    crs_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start),
      .num   (dnum[g]),
      .den   (dden[g]),
      .busy  (busy[g]),
      .quo   (quo[g])
    );
  end

  always_comb begin
    if (quo[0] > S32_MAX) rx = 32'h7FFF_FFFF;
    else if (quo[0] < S32_MIN) rx = 32'h8000_0000;
    else rx = quo[0][31:0];
    if (quo[1] > S32_MAX) ry = 32'h7FFF_FFFF;
    else if (quo[1] < S32_MIN) ry = 32'h8000_0000;
    else ry = quo[1][31:0];
    if (quo[2] < 0) rp = 16'd0;
    else if (quo[2] > U16_MAX) rp = 16'hFFFF;
    else rp = quo[2][15:0];
    rs = quo[3][31:0];
  end

  assign last_pt = (job_r.kind != crs_pkg::JOB_SEG) || (j_r == job_r.n);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crs_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = (head.kind == crs_pkg::JOB_SEG) ? crs_pkg::B_SQ : crs_pkg::B_EMIT;
        end
      end
      crs_pkg::B_SQ:   state_nxt = crs_pkg::B_CUBE;
      crs_pkg::B_CUBE: state_nxt = crs_pkg::B_MUL;
      crs_pkg::B_MUL:  state_nxt = crs_pkg::B_SUM;
      crs_pkg::B_SUM:  state_nxt = crs_pkg::B_KMUL;
      crs_pkg::B_KMUL: state_nxt = crs_pkg::B_PRE;
      crs_pkg::B_PRE:  state_nxt = crs_pkg::B_DIV;
      crs_pkg::B_DIV: begin
        if (busy == 4'd0) begin
          state_nxt = crs_pkg::B_EMIT;
        end
      end
      crs_pkg::B_EMIT: begin
        if (free) begin
          state_nxt = last_pt ? crs_pkg::B_IDLE : crs_pkg::B_SQ;
        end
      end
      default: state_nxt = crs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    start = 1'b0;
    case (state_r)
      crs_pkg::B_IDLE: pop = !qstat.empty;
      crs_pkg::B_PRE:  start = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    j_nxt = j_r;
    if (pop) begin
      j_nxt = 5'd1;
    end else if (state_r == crs_pkg::B_EMIT && free && !last_pt) begin
      j_nxt = j_r + 5'd1;
    end
    out_valid_nxt = out_valid_r;
    if (state_r == crs_pkg::B_EMIT && free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crs_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    if (state_r == crs_pkg::B_SQ) begin
      j2_r <= 10'(j_r) * 10'(j_r);
      n2_r <= 10'(job_r.n) * 10'(job_r.n);
      jn_r <= 10'(j_r) * 10'(job_r.n);
    end
    if (state_r == crs_pkg::B_CUBE) begin
      m_r  <= n3;
      h1_r <= 16'((cj3 <<< 1) - (cj2n + (cj2n <<< 1)) + cn3);
      h2_r <= 16'((cj2n + (cj2n <<< 1)) - (cj3 <<< 1));
      h3_r <= 16'(cj3 - (cj2n <<< 1) + cjn2);
      h4_r <= 16'(cj3 - cj2n);
      for (int c = 0; c < 3; c++) begin
        d20_r[c] <= 34'(v[c][2]) - 34'(v[c][0]);
        d31_r[c] <= 34'(v[c][3]) - 34'(v[c][1]);
      end
    end
    if (state_r == crs_pkg::B_MUL) begin
      for (int c = 0; c < 3; c++) begin
        p1_r[c] <= 50'(h1_r) * 50'(v[c][1]);
        p2_r[c] <= 50'(h2_r) * 50'(v[c][2]);
        p3_r[c] <= 50'(h3_r) * 50'(d20_r[c]);
        p4_r[c] <= 50'(h4_r) * 50'(d31_r[c]);
      end
      sb_r <= $signed({8'd0, job_r.b.st}) * $signed({35'd0, job_r.n});
      sj_r <= 40'(dst) * $signed({35'd0, j_r});
    end
    if (state_r == crs_pkg::B_SUM) begin
      for (int c = 0; c < 3; c++) begin
        s_r[c] <= 51'(p1_r[c]) + 51'(p2_r[c]);
        t_r[c] <= 51'(p3_r[c]) + 51'(p4_r[c]);
      end
      ns_r <= sb_r + sj_r + $signed({36'd0, job_r.n[4:1]});
    end
    if (state_r == crs_pkg::B_KMUL) begin
      for (int c = 0; c < 3; c++) begin
        kt_r[c] <= 64'(job_r.k) * 64'(t_r[c]);
      end
    end
    if (state_r == crs_pkg::B_EMIT && free) begin
      out_run_end <= job_r.last && last_pt;
      out_status  <= (job_r.kind == crs_pkg::JOB_ERR);
      case (job_r.kind)
        crs_pkg::JOB_SEG: begin
          out_x        <= rx;
          out_y        <= ry;
          out_pressure <= rp;
          out_stamp    <= rs;
        end
        crs_pkg::JOB_FIRST: begin
          out_x        <= job_r.a.x;
          out_y        <= job_r.a.y;
          out_pressure <= job_r.a.pr;
          out_stamp    <= job_r.a.st;
        end
        default: begin
          out_x        <= '0;
          out_y        <= '0;
          out_pressure <= '0;
          out_stamp    <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_err_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> out_run_end)
    else $error("error result without run end");
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (busy != 4'd0) |-> (state_r == crs_pkg::B_DIV))
    else $error("divider busy outside divide state");

endmodule

`default_nettype wire

// ===== rtl/catmull_rom_stroke_subdivider.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_stroke_subdivider
// Cardinal Catmull-Rom subdivision of pen strokes.
// ----------------------------------------------------------------------------
// Input channel in_*: one stroke point per item, in_final_point on the last.
// Output channel out_*: curve points; out_run_end marks the last point caused
// by an input item, out_status flags a stroke of fewer than four points.
// Config channel cfg_*: index 0 tension (Q2.14), index 1 subdivisions n;
// cfg_ready is always high, writes are meant for idle periods.
// The first three points of a stroke give no output unless one ends the stroke.
// Later points become jobs (first point, segments) in a four-entry queue.
// Each curve point runs the multiply, add and divider start states B_SQ,
// B_CUBE, B_MUL, B_SUM, B_KMUL and B_PRE, waits in B_DIV for the iterative
// dividers, which retire two quotient bits per cycle, and is registered in
// B_EMIT. Each job is taken from the queue in B_IDLE. A mid-stroke point
// gives one segment job, the fourth point a first-point job and two segment
// jobs (three if also last), the last point two, a short stroke an error job.
// Reset clears the window, restores tension 0.5 and n = 4.
// A stalled receiver holds the result register; the back stops, the queue
// fills and then the input side stops taking items.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_stroke_subdivider #(
  parameter int MAX_SUBDIV = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic [15:0]        in_pen_pressure,
  input  wire logic [31:0]        in_stamp,
  input  wire logic               in_final_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic [15:0]             out_pressure,
  output logic [31:0]             out_stamp,
  output logic                    out_run_end,
  output logic                    out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  crs_pkg::job_t    job_in, job_head;
  crs_pkg::q_stat_t qstat;
  logic             push, pop;

  assign cfg_ready = 1'b1;

  crs_front #(
    .MAX_SUBDIV (MAX_SUBDIV)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pen_pressure (in_pen_pressure),
    .in_stamp        (in_stamp),
    .in_final_point  (in_final_point),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .job             (job_in),
    .qstat           (qstat)
  );

  crs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_head),
    .stat  (qstat)
  );

  crs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (job_head),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_pressure (out_pressure),
    .out_stamp    (out_stamp),
    .out_run_end  (out_run_end),
    .out_status   (out_status)
  );

endmodule

`default_nettype wire
